// ----- rtl/srms_pkg.sv -----
// shared types and constants for the sorted row marker set
`timescale 1ns / 1ps

package srms_pkg;

    // fixed widths of the beat fields
    localparam int ROW_W   = 16;
    localparam int COUNT_W = 7;

    // defaults for the top level parameters
    localparam int MAX_MARKS_DEF = 64;
    localparam int ROW_BITS_DEF  = 16;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic load_flags;
        logic do_insert;
        logic do_remove;
    } cell_ctrl_t;

    // neighbor lookup result for one row
    typedef struct packed {
        logic             is_marked;
        logic             prev_valid;
        logic [ROW_W-1:0] prev_mark;
        logic             next_valid;
        logic [ROW_W-1:0] next_mark;
    } pick_t;

endpackage

// ----- rtl/sorted_row_marker_set.sv -----
// an accepted input beat passes the compare, update, compare and select steps before out_valid
// a new input beat is taken only in idle, once the previous beat has done its four-step pass over the cells
// a new input beat is taken while the previous result still waits in the output register
// reset: rst_n clears the mark count, sequencer and output valid; mark cells are not reset
// and are never read above the count
`timescale 1ns / 1ps

module sorted_row_marker_set #(
    parameter int MAX_MARKS = srms_pkg::MAX_MARKS_DEF,
    parameter int ROW_BITS  = srms_pkg::ROW_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           mode,
    input  logic [srms_pkg::ROW_W-1:0]     row,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           is_marked,
    output logic                           prev_valid,
    output logic [srms_pkg::ROW_W-1:0]     prev_mark,
    output logic                           next_valid,
    output logic [srms_pkg::ROW_W-1:0]     next_mark,
    output logic [srms_pkg::COUNT_W-1:0]   mark_count,
    output logic                           full_refused
);

    // stored mark width: the smaller of ROW_BITS and the port width; row bits above it never reach the cells
    localparam int MW = (ROW_BITS < srms_pkg::ROW_W) ? ROW_BITS : srms_pkg::ROW_W;
    localparam int CW = $clog2(MAX_MARKS + 1);
    localparam int N  = MAX_MARKS;

    // sequencer codes
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CMP1 = 3'd1;
    localparam logic [2:0] S_UPD  = 3'd2;
    localparam logic [2:0] S_CMP2 = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]    state_reg;
    logic [2:0]    state_next;
    logic          mode_reg;
    logic          mode_next;
    logic [MW-1:0] row_reg;
    logic [MW-1:0] row_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          refused_reg;
    logic          refused_next;

    // output register
    logic                              out_valid_reg;
    logic                              out_valid_next;
    srms_pkg::pick_t                   res_reg;
    srms_pkg::pick_t                   res_next;
    logic [CW-1:0]                     res_count_reg;
    logic [CW-1:0]                     res_count_next;
    logic                              res_refused_reg;
    logic                              res_refused_next;

    srms_pkg::cell_ctrl_t ctrl;
    srms_pkg::pick_t      pick_res;

    logic [N-1:0]  below_v;
    logic [N-1:0]  eq_v;
    logic [N-1:0]  valid_v;
    logic [MW-1:0] mark_v [N];

    logic found;
    logic full;
    logic accept_in;
    logic load_out;

    assign found     = |eq_v;
    assign full      = (count_reg == CW'(MAX_MARKS));
    assign in_ready  = (state_reg == S_IDLE);
    assign accept_in = in_valid && in_ready;
    // the select stage only retires into a free (or draining) output register
    assign load_out  = (state_reg == S_OUT) && (!out_valid_reg || out_ready);

    // slot i holds a live mark when it sits below the count
    genvar gi;
    generate
        for (gi = 0; gi < N; gi++)
        begin : g_valid
            assign valid_v[gi] = (CW'(gi) < count_reg);
        end
    endgenerate

    // the row of cells, each talking only to its two neighbors
    generate
        for (gi = 0; gi < N; gi++)
        begin : g_cell
            logic          lb;
            logic [MW-1:0] lm;
            logic [MW-1:0] rm;
            if (gi == 0)
            begin : g_first
                assign lb = 1'b1;
                assign lm = row_reg;
            end
            else
            begin : g_mid
                assign lb = below_v[gi-1];
                assign lm = mark_v[gi-1];
            end
            if (gi == N - 1)
            begin : g_last
                assign rm = mark_v[gi];
            end
            else
            begin : g_inner
                assign rm = mark_v[gi+1];
            end
            srms_cell #(
                .MW(MW)
            ) u_cell (
                .clk       (clk),
                .row       (row_reg),
                .slot_valid(valid_v[gi]),
                .left_below(lb),
                .left_mark (lm),
                .right_mark(rm),
                .ctrl      (ctrl),
                .mark      (mark_v[gi]),
                .below     (below_v[gi]),
                .eq        (eq_v[gi])
            );
        end
    endgenerate

    srms_pick #(
        .N (N),
        .MW(MW)
    ) u_pick (
        .below     (below_v),
        .eq        (eq_v),
        .slot_valid(valid_v),
        .marks     (mark_v),
        .result    (pick_res)
    );

    // sequencer: capture, compare, shift on a toggle, compare again, select
    always_comb
    begin
        state_next   = state_reg;
        mode_next    = mode_reg;
        row_next     = row_reg;
        count_next   = count_reg;
        refused_next = refused_reg;
        ctrl         = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept_in)
                begin
                    mode_next    = mode;
                    row_next     = row[MW-1:0];
                    refused_next = 1'b0;
                    state_next   = S_CMP1;
                end
            end
            S_CMP1:
            begin
                ctrl.load_flags = 1'b1;
                state_next      = S_UPD;
            end
            S_UPD:
            begin
                if (mode_reg)
                begin
                    if (found)
                    begin
                        ctrl.do_remove = 1'b1;
                        count_next     = count_reg - CW'(1);
                    end
                    else if (full)
                    begin
                        refused_next = 1'b1;
                    end
                    else
                    begin
                        ctrl.do_insert = 1'b1;
                        count_next     = count_reg + CW'(1);
                    end
                end
                state_next = S_CMP2;
            end
            S_CMP2:
            begin
                // flags now reflect the set after any toggle
                ctrl.load_flags = 1'b1;
                state_next      = S_OUT;
            end
            S_OUT:
            begin
                if (load_out)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next   = out_valid_reg;
        res_next         = res_reg;
        res_count_next   = res_count_reg;
        res_refused_next = res_refused_reg;
        if (load_out)
        begin
            out_valid_next   = 1'b1;
            res_next         = pick_res;
            res_count_next   = count_reg;
            res_refused_next = refused_reg;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        mode_reg        <= mode_next;
        row_reg         <= row_next;
        refused_reg     <= refused_next;
        res_reg         <= res_next;
        res_count_reg   <= res_count_next;
        res_refused_reg <= res_refused_next;
    end

    assign out_valid    = out_valid_reg;
    assign is_marked    = res_reg.is_marked;
    assign prev_valid   = res_reg.prev_valid;
    assign prev_mark    = res_reg.prev_mark;
    assign next_valid   = res_reg.next_valid;
    assign next_mark    = res_reg.next_mark;
    assign mark_count   = srms_pkg::COUNT_W'(res_count_reg);
    assign full_refused = res_refused_reg;

`ifndef NO_ASSERTIONS
    // count never exceeds the cell row
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_MARKS))
        else $error("mark count above capacity");

    // a refused insert only happens on a full set
    a_refuse_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP2) && refused_reg |-> full)
        else $error("insert refused on a set that is not full");

    // sorted cells give a prefix of below flags
    a_below_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPD) || (state_reg == S_OUT) |->
        ((below_v & ~{below_v[N-2:0], 1'b1}) == '0))
        else $error("below flags are not a prefix");

    // no duplicates: at most one cell matches the row
    a_eq_single: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPD) || (state_reg == S_OUT) |-> $onehot0(eq_v))
        else $error("duplicate mark in the set");

    // count moves by at most one per item update
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP2) |->
        (count_reg == $past(count_reg)) || (count_reg == $past(count_reg) + CW'(1)) ||
        (count_reg == $past(count_reg) - CW'(1)))
        else $error("count changed by more than one");
`endif

endmodule

// ----- rtl/srms_cell.sv -----
// one slot of the sorted mark row: holds a mark, compares it, shifts with neighbors
`timescale 1ns / 1ps

module srms_cell #(
    parameter int MW = srms_pkg::ROW_BITS_DEF
) (
    input  logic                clk,
    input  logic [MW-1:0]       row,
    input  logic                slot_valid,
    input  logic                left_below,
    input  logic [MW-1:0]       left_mark,
    input  logic [MW-1:0]       right_mark,
    input  srms_pkg::cell_ctrl_t ctrl,
    output logic [MW-1:0]       mark,
    output logic                below,
    output logic                eq
);

    logic [MW-1:0] mark_reg;
    logic [MW-1:0] mark_next;
    logic          below_reg;
    logic          below_next;
    logic          eq_reg;
    logic          eq_next;

    always_comb
    begin
        mark_next = mark_reg;
        if (ctrl.do_insert && !below_reg)
        begin
            // first slot at or above the row takes it, later slots take the left value
            mark_next = left_below ? row : left_mark;
        end
        else if (ctrl.do_remove && !below_reg)
        begin
            mark_next = right_mark;
        end
    end

    always_comb
    begin
        below_next = below_reg;
        eq_next    = eq_reg;
        if (ctrl.load_flags)
        begin
            below_next = slot_valid && (mark_reg < row);
            eq_next    = slot_valid && (mark_reg == row);
        end
    end

    always_ff @(posedge clk)
    begin
        mark_reg  <= mark_next;
        below_reg <= below_next;
        eq_reg    <= eq_next;
    end

    assign mark  = mark_reg;
    assign below = below_reg;
    assign eq    = eq_reg;

endmodule

// ----- rtl/srms_pick.sv -----
// one-hot neighbor select across the cell row flags
`timescale 1ns / 1ps

module srms_pick #(
    parameter int N  = srms_pkg::MAX_MARKS_DEF,
    parameter int MW = srms_pkg::ROW_BITS_DEF
) (
    input  logic [N-1:0]  below,
    input  logic [N-1:0]  eq,
    input  logic [N-1:0]  slot_valid,
    input  logic [MW-1:0] marks [N],
    output srms_pkg::pick_t result
);

    logic [N-1:0]  prev_hit;
    logic [N-1:0]  next_hit;
    logic [MW-1:0] prev_sel;
    logic [MW-1:0] next_sel;

    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            // last mark below the row, and the slot right after it
            if (i == N - 1)
                prev_hit[i] = below[i];
            else
                prev_hit[i] = below[i] && !below[i+1];
            if (i == 0)
                next_hit[i] = slot_valid[i] && !below[i];
            else
                next_hit[i] = slot_valid[i] && !below[i] && below[i-1];
        end
    end

    always_comb
    begin
        prev_sel = '0;
        next_sel = '0;
        for (int i = 0; i < N; i++)
        begin
            prev_sel = prev_sel | (marks[i] & {MW{prev_hit[i]}});
            next_sel = next_sel | (marks[i] & {MW{next_hit[i]}});
        end
    end

    always_comb
    begin
        result            = '0;
        result.is_marked  = |eq;
        result.prev_valid = below[0];
        result.prev_mark  = srms_pkg::ROW_W'(prev_sel);
        result.next_valid = |next_hit;
        result.next_mark  = srms_pkg::ROW_W'(next_sel);
    end

endmodule
